// ----- rtl/dcla_pkg.sv -----
// Shared types, constants and helpers for the dual-channel latency arbiter.
// Depends on nothing; the channel, result queue and top level use it by scoped names.
`default_nettype none

package dcla_pkg;

  // Sizing of the arbiter.
  localparam int unsigned NUM_PORTS = 4;
  localparam int unsigned LAT_BITS  = 16;
  localparam int unsigned PORT_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // Fixed widths of the stream fields.
  localparam int unsigned ID_W     = 2;
  localparam int unsigned LAT_IN_W = 16;

  // Result queue; the depth must be a power of two so the pointers wrap.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef logic [PORT_W-1:0]    port_t;
  typedef logic [LAT_BITS-1:0]  lat_t;
  typedef logic [NUM_PORTS-1:0] pend_t;

  typedef enum logic [1:0] {
    EV_ACCEPT     = 2'd0,
    EV_REJECT     = 2'd1,
    EV_READ_DONE  = 2'd2,
    EV_WRITE_DONE = 2'd3
  } event_kind_e;

  // One result transaction.
  typedef struct packed {
    event_kind_e kind;
    logic [1:0]  port;
    logic        last;
  } result_t;

  // Command from the top level to one channel.
  typedef struct packed {
    logic  req;
    logic  tick;
    port_t id;
    lat_t  latency;
  } chan_cmd_t;

  // Status from one channel to the top level.
  typedef struct packed {
    logic  slot_busy;
    logic  done;
    port_t done_port;
    logic  loading;
  } chan_sts_t;

  typedef struct packed {
    logic  found;
    port_t idx;
  } pick_t;

  // Highest-numbered set bit of a pending vector.
  function automatic pick_t pick_highest(pend_t pend);
    pick_t r;
    r = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (pend[i]) begin
        r.found = 1'b1;
        r.idx   = PORT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dcla_slot_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; used by the channel controller to hold slot latencies.
`default_nettype none

module dcla_slot_ram #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dcla_channel.sv -----
// One arbitration channel: pending bits, service owner and countdown, with the
// slot latencies in a synchronous RAM. Depends on dcla_pkg and dcla_slot_ram.
`default_nettype none

module dcla_channel (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dcla_pkg::chan_cmd_t  cmd_i,
  output dcla_pkg::chan_sts_t       sts_o
);

  dcla_pkg::pend_t pending_q, pending_d;
  logic            active_q, active_d;
  dcla_pkg::port_t owner_q, owner_d;
  dcla_pkg::lat_t  countdown_q, countdown_d;
  logic            load_q, load_d;

  logic            ram_we;
  logic            ram_re;
  dcla_pkg::lat_t  ram_rdata;
  dcla_pkg::pend_t pend_clr;
  dcla_pkg::pick_t pick;
  logic            slot_busy;
  logic            done;

  // Slot latency storage, written on request and read when a new owner starts.
  dcla_slot_ram #(
    .DEPTH(dcla_pkg::NUM_PORTS),
    .WIDTH(dcla_pkg::LAT_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_i.id),
    .wdata_i(cmd_i.latency),
    .re_i   (ram_re),
    .raddr_i(pick.idx),
    .rdata_o(ram_rdata)
  );

  // Current service finishes on this tick when the count is zero or one.
  assign slot_busy = pending_q[cmd_i.id];
  assign done      = active_q && (countdown_q <= dcla_pkg::lat_t'(1));
  assign pend_clr  = pending_q & ~(dcla_pkg::pend_t'(1) << owner_q);
  assign pick      = dcla_pkg::pick_highest(pend_clr);

  // Next state of the channel.
  always_comb begin
    pending_d   = pending_q;
    active_d    = active_q;
    owner_d     = owner_q;
    countdown_d = countdown_q;
    load_d      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (load_q) begin
      // The new owner's latency arrives from the RAM.
      countdown_d = ram_rdata;
    end else if (cmd_i.req && !slot_busy) begin
      pending_d[cmd_i.id] = 1'b1;
      ram_we              = 1'b1;
      if (!active_q) begin
        active_d    = 1'b1;
        owner_d     = cmd_i.id;
        countdown_d = cmd_i.latency;
      end
    end else if (cmd_i.tick && active_q) begin
      if (done) begin
        pending_d   = pend_clr;
        active_d    = pick.found;
        owner_d     = pick.found ? pick.idx : '0;
        countdown_d = '0;
        load_d      = pick.found;
        ram_re      = pick.found;
      end else begin
        countdown_d = countdown_q - dcla_pkg::lat_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      active_q    <= 1'b0;
      owner_q     <= '0;
      countdown_q <= '0;
      load_q      <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      active_q    <= active_d;
      owner_q     <= owner_d;
      countdown_q <= countdown_d;
      load_q      <= load_d;
    end
  end

  assign sts_o.slot_busy = slot_busy;
  assign sts_o.done      = done;
  assign sts_o.done_port = owner_q;
  assign sts_o.loading   = load_q;

  // A RAM load only follows the start of a new owner.
  a_load_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_q |-> active_q)
    else $error("channel loads a countdown while idle");

  // The owner in service always holds a pending slot.
  a_owner_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> pending_q[owner_q])
    else $error("active owner has no pending slot");

  // An accepted request leaves its slot pending.
  a_req_sets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.req && !slot_busy && !load_q) |=> pending_q[$past(cmd_i.id)])
    else $error("accepted request did not set its pending bit");

endmodule

`default_nettype wire

// ----- rtl/dcla_result_fifo.sv -----
// Small result queue that takes up to two results per cycle and drives the
// output stream. Depends on dcla_pkg.
`default_nettype none

module dcla_result_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         push_cnt_i,
  input  wire dcla_pkg::result_t  push0_i,
  input  wire dcla_pkg::result_t  push1_i,
  output logic                    room2_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output dcla_pkg::result_t       data_o
);

  dcla_pkg::result_t                   buf_q [dcla_pkg::RES_DEPTH];
  logic [dcla_pkg::RES_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [dcla_pkg::RES_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [dcla_pkg::RES_CNT_W-1:0]      count_q, count_d;
  logic                                pop;
  logic [dcla_pkg::RES_PTR_W-1:0]      wr_ptr_p1;

  assign valid_o   = (count_q != '0);
  assign data_o    = buf_q[rd_ptr_q];
  assign pop       = valid_o && ready_i;
  assign room2_o   = (count_q <= dcla_pkg::RES_CNT_W'(dcla_pkg::RES_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_q + dcla_pkg::RES_PTR_W'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + dcla_pkg::RES_PTR_W'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + dcla_pkg::RES_PTR_W'(pop);
    count_d  = count_q + dcla_pkg::RES_CNT_W'(push_cnt_i) - dcla_pkg::RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage of queued results.
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      buf_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      buf_q[wr_ptr_p1] <= push1_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dual_channel_latency_arbiter_unit.sv -----
// Dual-channel latency arbiter: a read and a write channel, each with one
// pending slot per requester, and a result queue in front of the output.
//
// Input stream (s_axis): one transaction is either a tick (tuser[0] = 0) or a
// request (tuser[0] = 1) on the channel that tuser[1] selects, carrying the
// requester index and its latency in ticks. Output stream (m_axis): one
// transaction per event; tuser holds the event kind, tdata the port and tlast
// marks the final result of one input transaction.
// A request gives one result; a tick gives zero, one or two results (read
// done before write done).
// Throughput: one input transaction per cycle while the queue has room for two
// results, except that a tick that ends a service and starts a waiting requester
// holds the input while the new owner's latency is read from the registered slot
// RAM. Results pass through the result queue registers before reaching m_axis.
// When the receiver stalls, results wait in a four-entry queue; the input is
// taken only while the queue has room for two more results.
// Reset clears all pending bits and idles both channels; the slot RAMs are
// not cleared, since a slot is only read after it has been written.
`default_nettype none

module dual_channel_latency_arbiter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // requester_id[1:0], latency[17:2], zero fill
  input  wire logic [1:0]  s_axis_tuser,   // command[0], is_write[1]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,   // port_id[1:0], zero fill
  output logic      [1:0]  m_axis_tuser,   // event_kind[1:0]
  output logic             m_axis_tlast    // last_result
);

  localparam int unsigned PortW = dcla_pkg::PORT_W;
  localparam int unsigned LatW  = dcla_pkg::LAT_BITS;

  logic                           accept;
  logic                           command;
  logic                           is_write;
  logic [dcla_pkg::ID_W-1:0]      requester_id;
  logic [dcla_pkg::LAT_IN_W-1:0]  latency;
  logic                           in_range;
  dcla_pkg::port_t                id;
  dcla_pkg::chan_cmd_t            rd_cmd, wr_cmd;
  dcla_pkg::chan_sts_t            rd_sts, wr_sts;
  logic                           room2;
  logic [1:0]                     push_cnt;
  dcla_pkg::result_t              push0, push1;
  dcla_pkg::result_t              head;
  logic                           busy_sel;

  // Field extraction and input handshake.
  assign command      = s_axis_tuser[0];
  assign is_write     = s_axis_tuser[1];
  assign requester_id = s_axis_tdata[1:0];
  assign latency      = s_axis_tdata[17:2];
  assign in_range     = (32'(requester_id) < dcla_pkg::NUM_PORTS);
  assign id           = PortW'(requester_id);

  assign s_axis_tready = !(rd_sts.loading || wr_sts.loading) && room2;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Commands to the two channels.
  always_comb begin
    rd_cmd.req     = accept && command && !is_write && in_range;
    rd_cmd.tick    = accept && !command;
    rd_cmd.id      = id;
    rd_cmd.latency = LatW'(latency);
    wr_cmd.req     = accept && command && is_write && in_range;
    wr_cmd.tick    = accept && !command;
    wr_cmd.id      = id;
    wr_cmd.latency = LatW'(latency);
  end

  dcla_channel u_read_ch (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (rd_cmd),
    .sts_o (rd_sts)
  );

  dcla_channel u_write_ch (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (wr_cmd),
    .sts_o (wr_sts)
  );

  assign busy_sel = is_write ? wr_sts.slot_busy : rd_sts.slot_busy;

  // Result formation for the accepted transaction.
  always_comb begin
    push_cnt = 2'd0;
    push0    = '0;
    push1    = '0;
    if (accept) begin
      if (command) begin
        push_cnt   = 2'd1;
        push0.kind = (!in_range || busy_sel) ? dcla_pkg::EV_REJECT : dcla_pkg::EV_ACCEPT;
        push0.port = requester_id;
        push0.last = 1'b1;
      end else if (rd_sts.done) begin
        push0.kind = dcla_pkg::EV_READ_DONE;
        push0.port = 2'(rd_sts.done_port);
        push0.last = !wr_sts.done;
        push1.kind = dcla_pkg::EV_WRITE_DONE;
        push1.port = 2'(wr_sts.done_port);
        push1.last = 1'b1;
        push_cnt   = wr_sts.done ? 2'd2 : 2'd1;
      end else if (wr_sts.done) begin
        push_cnt   = 2'd1;
        push0.kind = dcla_pkg::EV_WRITE_DONE;
        push0.port = 2'(wr_sts.done_port);
        push0.last = 1'b1;
      end
    end
  end

  dcla_result_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(push_cnt),
    .push0_i   (push0),
    .push1_i   (push1),
    .room2_o   (room2),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .data_o    (head)
  );

  // Output packing.
  assign m_axis_tdata = {6'b0, head.port};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire
